/* rtl/mm3_pkg.sv */
// ----------------------------------------------------------------------------
// mm3_pkg: shared types and constants for the MurmurHash3 bucket hasher
// Holds the key and result word structs, the hash constants and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package mm3_pkg;

	// One key word as it arrives on the input channel.
	typedef struct packed {
		logic [31:0] key_word;
		logic [2:0]  bytes_valid;
		logic        last;
	} key_word_t;

	// One result word as it leaves on the output channel.
	typedef struct packed {
		logic [15:0] bucket;
		logic [31:0] full_hash;
	} res_word_t;

	// MurmurHash3 x86_32 constants.
	localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2 = 32'h1b873593;
	localparam logic [31:0] MM_N  = 32'he6546b64;
	localparam logic [31:0] MM_F1 = 32'h85ebca6b;
	localparam logic [31:0] MM_F2 = 32'hc2b2ae35;
	localparam logic [31:0] SEED  = 32'h00000001;

	// Table size register.
	localparam int unsigned TS_W           = 17;
	localparam int unsigned BUCKET_W       = 16;
	localparam logic [TS_W-1:0] TS_RESET   = 17'd1024;
	localparam logic [TS_W-1:0] TS_MAX     = 17'd65536;

	// Register map: index taken from the word address.
	localparam int unsigned PADDR_W        = 3;
	localparam logic        REG_TABLE_SIZE = 1'b0;

	// Byte counts of a key word.
	localparam logic [2:0] NB_NONE = 3'd0;
	localparam logic [2:0] NB_ONE  = 3'd1;
	localparam logic [2:0] NB_TWO  = 3'd2;
	localparam logic [2:0] NB_FULL = 3'd4;

endpackage

/* rtl/mm3_mod.sv */
// ----------------------------------------------------------------------------
// mm3_mod: iterative remainder unit
// Restoring division of a 32-bit dividend by a divisor of up to 65536,
// one quotient bit a cycle. Only the remainder is kept. A zero divisor
// gives a zero remainder.
// ----------------------------------------------------------------------------
module mm3_mod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [31:0]                    dividend,
	input  logic [mm3_pkg::TS_W-1:0]       divisor,
	output logic                           busy,
	output logic                           done,
	output logic [mm3_pkg::BUCKET_W-1:0]   remainder
);

	logic                           busy_q;
	logic                           done_q;
	logic [4:0]                     cnt_q;
	logic [31:0]                    dvd_q;
	logic [mm3_pkg::TS_W-1:0]       div_q;
	logic [mm3_pkg::BUCKET_W-1:0]   rem_q;
	logic [mm3_pkg::TS_W-1:0]       trial;
	logic                           fits;

	// Bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, dvd_q[31]};
	assign fits  = (trial >= div_q);

	// Control: a fixed run of 32 steps after each start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: partial remainder and the dividend shifting out.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (fits) begin
				rem_q <= mm3_pkg::BUCKET_W'(trial - div_q);
			end else begin
				rem_q <= trial[mm3_pkg::BUCKET_W-1:0];
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign remainder = (div_q == '0) ? '0 : rem_q;

endmodule

/* rtl/murmur3_bucket_hash.sv */
// ----------------------------------------------------------------------------
// murmur3_bucket_hash: streaming MurmurHash3 x86_32 with a bucket index
// Hashes a key given as 32-bit little-endian words with seed 1, then
// reduces the finished hash modulo the configured table size.
// ----------------------------------------------------------------------------
//
//  Channel  Valid      Stall      Data        Word
//  -------  ---------  ---------  ----------  ------------------------------
//  key      key_valid  key_stall  key         key_word, bytes_valid, last
//  res      res_valid  res_stall  res         bucket, full_hash
//  config   psel/penable/pwrite   paddr/pwdata  table_size at address 0
//
// A full key word passes through accept, two passes through the shared
// 32x32 multiplier, and the body mix; a partial last word ends in the tail mix.
// The last word then goes through the finalize steps (two more multiplier
// passes) and the bit-serial remainder unit.
// The result sits in an output register, so the next key is taken while
// it waits; a second finished key waits until that register is free.
// Reset sets the running hash to the seed, the length to zero and the
// table size to 1024.
//
module murmur3_bucket_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mm3_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// Key words.
	input  logic                          key_valid,
	output logic                          key_stall,
	input  mm3_pkg::key_word_t            key,
	// Results.
	output logic                          res_valid,
	input  logic                          res_stall,
	output mm3_pkg::res_word_t            res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_C1,
		S_C2,
		S_MIX,
		S_TAIL,
		S_FIN0,
		S_F1,
		S_F2,
		S_MODST,
		S_MODW
	} state_t;

	state_t                       state_q;
	logic [mm3_pkg::TS_W-1:0]     ts_q;
	logic [31:0]                  hash_q;
	logic [31:0]                  cnt_q;
	logic [31:0]                  k_q;
	logic [31:0]                  fin_q;
	logic                         last_q;
	logic                         full_q;
	logic                         res_valid_q;
	mm3_pkg::res_word_t           res_q;

	logic                         key_acc;
	logic                         res_acc;
	logic                         res_load;
	logic                         cfg_wr;
	logic [2:0]                   nb_eff;
	logic [31:0]                  key_masked;
	logic [31:0]                  mul_a;
	logic [31:0]                  mul_b;
	logic [31:0]                  mul_p;
	logic [31:0]                  mix_rot;
	logic [31:0]                  fin_pre;
	logic [31:0]                  fin_out;
	logic [mm3_pkg::TS_W-1:0]     div_sat;
	logic                         mod_start;
	logic                         mod_busy;
	logic                         mod_done;
	logic [mm3_pkg::BUCKET_W-1:0] mod_rem;

	// Handshakes.
	assign key_stall = (state_q != S_IDLE);
	assign key_acc   = key_valid && !key_stall;
	assign res_acc   = res_valid_q && !res_stall;
	assign res_load  = (state_q == S_MODW) && mod_done && (!res_valid_q || !res_stall);

	// Configuration port: one writable register, no wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == mm3_pkg::REG_TABLE_SIZE) ? {15'd0, ts_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= mm3_pkg::TS_RESET;
		end else if (cfg_wr && (paddr[2] == mm3_pkg::REG_TABLE_SIZE)) begin
			ts_q <= pwdata[mm3_pkg::TS_W-1:0];
		end
	end

	// Divisor limited to the largest table.
	assign div_sat = (ts_q > mm3_pkg::TS_MAX) ? mm3_pkg::TS_MAX : ts_q;

	// Effective byte count: body words always count four.
	always_comb begin
		if (!key.last || (key.bytes_valid > mm3_pkg::NB_FULL)) begin
			nb_eff = mm3_pkg::NB_FULL;
		end else begin
			nb_eff = key.bytes_valid;
		end
	end

	// Mask off bytes above the valid count of a tail word.
	always_comb begin
		case (nb_eff)
			mm3_pkg::NB_ONE: key_masked = {24'd0, key.key_word[7:0]};
			mm3_pkg::NB_TWO: key_masked = {16'd0, key.key_word[15:0]};
			mm3_pkg::NB_FULL: key_masked = key.key_word;
			default: key_masked = {8'd0, key.key_word[23:0]};
		endcase
	end

	// Shared multiplier operand selection; low 32 bits of the product.
	always_comb begin
		unique case (state_q)
			S_C2: begin
				mul_a = {k_q[16:0], k_q[31:17]};
				mul_b = mm3_pkg::MM_C2;
			end
			S_F1: begin
				mul_a = fin_q;
				mul_b = mm3_pkg::MM_F1;
			end
			S_F2: begin
				mul_a = fin_q ^ (fin_q >> 13);
				mul_b = mm3_pkg::MM_F2;
			end
			default: begin
				mul_a = k_q;
				mul_b = mm3_pkg::MM_C1;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Body mix, start and end of the final avalanche.
	assign mix_rot = (hash_q ^ k_q) << 13 | (hash_q ^ k_q) >> 19;
	assign fin_pre = hash_q ^ cnt_q;
	assign fin_out = fin_q ^ (fin_q >> 16);

	assign mod_start = (state_q == S_MODST);

	mm3_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (fin_out),
		.divisor   (div_sat),
		.busy      (mod_busy),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// Sequencer with running hash state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hash_q  <= mm3_pkg::SEED;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (key_acc) begin
						cnt_q  <= cnt_q + {29'd0, nb_eff};
						last_q <= key.last;
						full_q <= (nb_eff == mm3_pkg::NB_FULL);
						if (nb_eff == mm3_pkg::NB_NONE) begin
							state_q <= S_FIN0;
						end else begin
							state_q <= S_C1;
						end
					end
				end
				S_C1: begin
					state_q <= S_C2;
				end
				S_C2: begin
					state_q <= full_q ? S_MIX : S_TAIL;
				end
				S_MIX: begin
					hash_q  <= (mix_rot << 2) + mix_rot + mm3_pkg::MM_N;
					state_q <= last_q ? S_FIN0 : S_IDLE;
				end
				S_TAIL: begin
					hash_q  <= hash_q ^ k_q;
					state_q <= S_FIN0;
				end
				S_FIN0: begin
					state_q <= S_F1;
				end
				S_F1: begin
					state_q <= S_F2;
				end
				S_F2: begin
					state_q <= S_MODST;
				end
				S_MODST: begin
					state_q <= S_MODW;
				end
				S_MODW: begin
					if (res_load) begin
						hash_q  <= mm3_pkg::SEED;
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Key word and avalanche working registers.
	always_ff @(posedge clk) begin
		if (key_acc) begin
			k_q <= key_masked;
		end else if ((state_q == S_C1) || (state_q == S_C2)) begin
			k_q <= mul_p;
		end
		if (state_q == S_FIN0) begin
			fin_q <= fin_pre ^ (fin_pre >> 16);
		end else if ((state_q == S_F1) || (state_q == S_F2)) begin
			fin_q <= mul_p;
		end else if (state_q == S_MODST) begin
			fin_q <= fin_out;
		end
	end

	// Output register: holds a finished word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_acc) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.bucket    <= mod_rem;
			res_q.full_hash <= fin_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// The remainder unit is running right after it is started.
	a_mod_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MODST) |=> mod_busy)
		else $error("remainder unit not busy after start");

	// A last word keeps the block busy for the following cycle.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(key_acc && key.last) |=> key_stall)
		else $error("key accepted right after a last word");

	// A loaded bucket lies inside the table.
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (((div_sat == '0) && (res.bucket == '0)) ||
			({1'b0, res.bucket} < div_sat)))
		else $error("bucket outside the table");

	// A result is only loaded once the remainder is finished.
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (mod_done && !mod_busy))
		else $error("result loaded before remainder finished");
`endif

endmodule

/* tb/tb_murmur3_bucket_hash.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_murmur3_bucket_hash: self-checking bench for the streaming hash block
// Streams keys as little-endian words into the hasher under random bursts
// and output stalls. A local MurmurHash3 x86_32 predictor (seed 1) works out
// each key's hash and bucket. Every result word is compared with the oldest
// prediction. The table size is changed between phases, including its extremes.
// ----------------------------------------------------------------------------
module tb_murmur3_bucket_hash;

	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned MAX_REPORTS   = 10;

	typedef enum int unsigned {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [mm3_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        key_valid = 1'b0;
	logic        key_stall;
	mm3_pkg::key_word_t key = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	mm3_pkg::res_word_t res;

	// Predictor state: running hash, key length so far and table size.
	logic [31:0]   acc_hash;
	logic [31:0]   key_len;
	logic [mm3_pkg::TS_W-1:0] table_size_cfg;

	mm3_pkg::key_word_t pending_words[$];
	mm3_pkg::res_word_t expected_res[$];
	mm3_pkg::res_word_t predicted;
	int unsigned words_queued;
	int unsigned mismatches;

	// Sender burst and receiver stall bookkeeping.
	int unsigned burst_left;
	int unsigned gap_left;
	stall_mode_t stall_mode;
	int unsigned mode_left;
	int unsigned cycle_cnt;

	murmur3_bucket_hash uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.key       (key),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	// Key word scramble of the MurmurHash3 body.
	function automatic logic [31:0] scramble(input logic [31:0] k);
		logic [31:0] t;
		t = k * mm3_pkg::MM_C1;
		t = rotl(t, 15);
		return t * mm3_pkg::MM_C2;
	endfunction

	// Advances the predictor by one word; returns 1 when the word ends a key.
	function automatic bit hash_word(input mm3_pkg::key_word_t w,
		output mm3_pkg::res_word_t r);
		logic [2:0]  nb;
		logic [31:0] h;
		logic [31:0] divisor;
		nb = (w.bytes_valid > mm3_pkg::NB_FULL) ? mm3_pkg::NB_FULL : w.bytes_valid;
		r = '0;
		if (!w.last) begin
			acc_hash = rotl(acc_hash ^ scramble(w.key_word), 13) * 32'd5 + mm3_pkg::MM_N;
			key_len  = key_len + 32'd4;
			return 1'b0;
		end
		if (nb == mm3_pkg::NB_FULL)
			acc_hash = rotl(acc_hash ^ scramble(w.key_word), 13) * 32'd5 + mm3_pkg::MM_N;
		else if (nb != mm3_pkg::NB_NONE)
			acc_hash = acc_hash ^ scramble(w.key_word & ((32'h1 << (8 * nb)) - 32'h1));
		key_len = key_len + 32'(nb);

		// Final avalanche.
		h = acc_hash ^ key_len;
		h = h ^ (h >> 16);
		h = h * mm3_pkg::MM_F1;
		h = h ^ (h >> 13);
		h = h * mm3_pkg::MM_F2;
		h = h ^ (h >> 16);

		divisor = (table_size_cfg > mm3_pkg::TS_MAX) ? 32'(mm3_pkg::TS_MAX) :
			32'(table_size_cfg);
		r.full_hash = h;
		r.bucket    = (divisor == 0) ? '0 : 16'(h % divisor);
		acc_hash = mm3_pkg::SEED;
		key_len  = '0;
		return 1'b1;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_word(input logic [31:0] data, input logic [2:0] nb, input logic fin);
		mm3_pkg::key_word_t w;
		w.key_word    = data;
		w.bytes_valid = nb;
		w.last        = fin;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// Mostly well-formed keys of random length; some carry odd byte counts.
	task automatic queue_random_key();
		int  n_body;
		bit  noisy;
		noisy  = ($urandom_range(0, 6) == 0);
		n_body = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
		for (int i = 0; i < n_body; i++)
			push_word(rand_word(),
				noisy ? 3'($urandom_range(0, 7)) : mm3_pkg::NB_FULL, 1'b0);
		push_word(rand_word(), noisy ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4)),
			1'b1);
	endtask

	// One write on the configuration port: setup cycle, then access cycle.
	task automatic write_table_size(input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {mm3_pkg::REG_TABLE_SIZE, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		table_size_cfg = value[mm3_pkg::TS_W-1:0];
	endtask

	// Holds off until every word is taken and every result is back.
	task automatic wait_idle();
		while (pending_words.size() != 0 || key_valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Driver: feeds key words in bursts with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid <= 1'b0;
			key       <= '0;
			burst_left = $urandom_range(1, 16);
			gap_left   = 0;
		end else begin
			if (key_valid && !key_stall) begin
				if (hash_word(key, predicted))
					expected_res.push_back(predicted);
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
						$urandom_range(1, 16);
				end
			end
			if (!(key_valid && key_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					key_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					key_valid <= 1'b1;
					key       <= pending_words.pop_front();
				end else begin
					key_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word and drives the receiver stall pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_mode = STALL_NONE;
			mode_left  = 0;
			cycle_cnt  = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					note_mismatch($sformatf("unexpected result: bucket %0d hash %08h",
						res.bucket, res.full_hash));
				end else begin
					predicted = expected_res.pop_front();
					if (res.bucket !== predicted.bucket)
						note_mismatch($sformatf("bucket: expected %0d, got %0d",
							predicted.bucket, res.bucket));
					if (res.full_hash !== predicted.full_hash)
						note_mismatch($sformatf("full_hash: expected %08h, got %08h",
							predicted.full_hash, res.full_hash));
				end
			end
			cycle_cnt++;
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE:  res_stall <= 1'b0;
				STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
				default:     res_stall <= ((cycle_cnt % 7) < 4);
			endcase
		end
	end

	// Stimulus: directed keys, then random keys over several table sizes.
	initial begin
		logic [31:0] ts_writes [7];
		int unsigned target;
		acc_hash       = mm3_pkg::SEED;
		key_len        = '0;
		table_size_cfg = mm3_pkg::TS_RESET;
		words_queued   = 0;
		mismatches     = 0;
		ts_writes[0] = 32'(mm3_pkg::TS_MAX);
		ts_writes[1] = 32'd1;
		ts_writes[2] = 32'd0;
		ts_writes[3] = 32'h0001_FFFF;
		ts_writes[4] = 32'd3;
		ts_writes[5] = $urandom_range(2, 65535);
		ts_writes[6] = 32'hFFFE_0000 | 32'($urandom_range(1, 65535));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty keys: the key word is ignored.
		push_word(32'hDEAD_BEEF, mm3_pkg::NB_NONE, 1'b1);
		push_word(32'h0000_0000, mm3_pkg::NB_NONE, 1'b1);
		// Tails of one to three bytes with junk above the valid bytes.
		push_word(32'hFFFF_FF61, mm3_pkg::NB_ONE, 1'b1);
		push_word(32'hA5A5_6261, mm3_pkg::NB_TWO, 1'b1);
		push_word(32'h1263_6261, 3'd3, 1'b1);
		// Last word with four bytes, and counts above four taken as four.
		push_word(32'h6463_6261, mm3_pkg::NB_FULL, 1'b1);
		push_word(32'hFFFF_FFFF, 3'd5, 1'b1);
		push_word(32'hFFFF_FFFF, 3'd6, 1'b1);
		push_word(32'hFFFF_FFFF, 3'd7, 1'b1);
		// Byte count on a body word is ignored.
		push_word(32'h0000_0000, mm3_pkg::NB_NONE, 1'b0);
		push_word(32'hFFFF_FFFF, mm3_pkg::NB_FULL, 1'b1);
		push_word(32'h8000_0001, 3'd7, 1'b0);
		push_word(32'h7FFF_FFFE, 3'd3, 1'b1);
		push_word(32'h0123_4567, 3'd3, 1'b0);
		push_word(32'h89AB_CDEF, mm3_pkg::NB_NONE, 1'b1);
		// A multi-word key of all ones.
		push_word(32'hFFFF_FFFF, mm3_pkg::NB_FULL, 1'b0);
		push_word(32'hFFFF_FFFF, mm3_pkg::NB_FULL, 1'b0);
		push_word(32'hFFFF_FFFF, mm3_pkg::NB_FULL, 1'b0);
		push_word(32'hFFFF_FFFF, mm3_pkg::NB_TWO, 1'b1);

		target = 110;
		while (words_queued < target)
			queue_random_key();
		wait_idle();

		// Each phase starts from an idle block with a new table size.
		for (int p = 0; p < 7; p++) begin
			write_table_size(ts_writes[p]);
			target = target + 92;
			while (words_queued < target)
				queue_random_key();
			wait_idle();
		end

		if (expected_res.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", expected_res.size()));
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
